// ----- hw/rtl/mtwg_pkg.sv -----
// Shared types, constants and word functions for the MT19937 word generator.
package mtwg_pkg;

    // Store geometry
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS);

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] FAR_WRAP   = IDX_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [IDX_W-1:0] FAR_STEP   = IDX_W'(TWIST_OFFSET);

    // Word constants
    localparam logic [31:0] FILL_MULT    = 32'd1812433253;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] RESET_SEED   = 32'd5489;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VARIANT = 2'd1;

    // Queue depths
    localparam int REQ_DEPTH = 2;
    localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
    localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Pending request from the front queue
    typedef struct packed {
        logic valid;
        logic halve;
    } t_req;

    // Raw store word on its way to the output stage
    typedef struct packed {
        logic        valid;
        logic        halve;
        logic [31:0] word;
    } t_rd;

    // Configuration write as seen by the engine
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } t_cfg_wr;

    // One twist step: far word, current word, next word
    function automatic logic [31:0] twist_word(input logic [31:0] far,
                                               input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic        legacy);
        logic [31:0] mixed;
        logic        sel;
        begin
            mixed = {cur[31], nxt[30:0]};
            sel   = legacy ? cur[0] : nxt[0];
            return far ^ (mixed >> 1) ^ (sel ? TWIST_MATRIX : 32'd0);
        end
    endfunction

    // Output tempering
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] t;
        begin
            t = w ^ (w >> 11);
            t = t ^ ((t << 7) & TEMPER_B);
            t = t ^ ((t << 15) & TEMPER_C);
            t = t ^ (t >> 18);
            return t;
        end
    endfunction

endpackage

// ----- hw/rtl/mtwg_front.sv -----
// Front request queue: accepts word requests and holds their halve flags.
module mtwg_front
    import mtwg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_halve,
    output t_req o_req,
    input  logic i_pop
);

    logic [REQ_DEPTH-1:0] r_flag;
    logic [REQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [REQ_CNT_W-1:0] r_count;
    logic                 push;

    assign o_in_stall = (r_count == REQ_CNT_W'(REQ_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_req.valid = (r_count != '0);
    assign o_req.halve = r_flag[r_rd_ptr];

    // Store flag payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_flag[r_wr_ptr] <= i_halve;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + REQ_CNT_W'(push) - REQ_CNT_W'(i_pop);
        end
    end

endmodule

// ----- hw/rtl/mtwg_engine.sv -----
// Word store engine: seeding fill, in-place twist and word reads.
module mtwg_engine
    import mtwg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg_wr              i_cfg,
    input  t_req                 i_req,
    output logic                 o_pop,
    input  logic [OUT_CNT_W-1:0] i_free,
    output t_rd                  o_rd
);

    localparam logic [1:0] ST_FILL   = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_TWLOAD = 2'd2;
    localparam logic [1:0] ST_TWRUN  = 2'd3;

    logic [31:0] r_store [STATE_WORDS];

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_pending, n_pending;
    logic [IDX_W-1:0] r_rp, n_rp;
    logic             r_wv, n_wv;
    logic             r_variant, n_variant;
    logic             r_inflight;
    logic             r_rd_halve;
    logic [31:0]      r_fill_prev, n_fill_prev;
    logic [31:0]      r_cur;
    logic [31:0]      r_rd_a, r_rd_b;

    logic [31:0]      fill_mix, fill_prod, fill_next, twisted, wr_data;
    logic [IDX_W-1:0] nxt_addr, far_addr, addr_a, wr_addr, cnt_inc;
    logic             wr_en, issue, start_twist, can_issue;

    // Seed recurrence and twist datapath
    always_comb begin
        cnt_inc   = r_cnt + 1'b1;
        fill_mix  = r_fill_prev ^ (r_fill_prev >> 30);
        fill_prod = fill_mix * FILL_MULT;
        fill_next = fill_prod + {{(32 - IDX_W){1'b0}}, cnt_inc};
        nxt_addr  = (r_cnt >= LAST_IDX) ? '0 : cnt_inc;
        far_addr  = (r_cnt >= FAR_WRAP) ? r_cnt - FAR_WRAP : r_cnt + FAR_STEP;
        twisted   = twist_word(r_rd_b, r_cur, r_rd_a, r_variant);
    end

    // Decide read issue toward the output stage
    assign can_issue   = (i_free > {{(OUT_CNT_W - 1){1'b0}}, r_inflight});
    assign issue       = (r_state == ST_IDLE) && i_req.valid && (r_pending != '0) && can_issue;
    assign start_twist = (r_state == ST_IDLE) && i_req.valid && (r_pending == '0);
    assign o_pop       = issue;

    // Select memory addresses and write data
    always_comb begin
        addr_a  = r_rp;
        wr_en   = 1'b0;
        wr_addr = r_cnt;
        wr_data = r_fill_prev;
        unique case (r_state)
            ST_FILL: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                addr_a = r_rp;
            end
            ST_TWLOAD: begin
                addr_a = '0;
            end
            ST_TWRUN: begin
                addr_a  = nxt_addr;
                wr_en   = r_wv;
                wr_addr = r_cnt - 1'b1;
                wr_data = twisted;
            end
            default: begin
                addr_a = r_rp;
            end
        endcase
    end

    // Word store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rd_a <= r_store[addr_a];
        r_rd_b <= r_store[far_addr];
    end

    // Sequence fill, twist and reads
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pending   = r_pending;
        n_rp        = r_rp;
        n_wv        = r_wv;
        n_variant   = r_variant;
        n_fill_prev = r_fill_prev;
        unique case (r_state)
            ST_FILL: begin
                n_fill_prev = fill_next;
                n_cnt       = cnt_inc;
                if (r_cnt == LAST_IDX) begin
                    n_state   = ST_IDLE;
                    n_pending = '0;
                    n_rp      = '0;
                end
            end
            ST_IDLE: begin
                if (issue) begin
                    n_pending = r_pending - 1'b1;
                    n_rp      = (r_rp >= LAST_IDX) ? '0 : r_rp + 1'b1;
                end else if (start_twist) begin
                    n_state = ST_TWLOAD;
                end
            end
            ST_TWLOAD: begin
                n_state = ST_TWRUN;
                n_cnt   = '0;
                n_wv    = 1'b0;
            end
            ST_TWRUN: begin
                n_wv  = 1'b1;
                n_cnt = cnt_inc;
                if (r_cnt == FULL_COUNT) begin
                    n_state   = ST_IDLE;
                    n_pending = FULL_COUNT;
                    n_rp      = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Configuration writes take effect at once
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEED: begin
                    n_state     = ST_FILL;
                    n_cnt       = '0;
                    n_fill_prev = i_cfg.data;
                    n_pending   = '0;
                    n_rp        = '0;
                end
                CFG_VARIANT: begin
                    n_variant = i_cfg.data[0];
                end
                default: begin
                    n_variant = r_variant;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_cnt       <= '0;
            r_pending   <= '0;
            r_rp        <= '0;
            r_wv        <= 1'b0;
            r_variant   <= 1'b0;
            r_inflight  <= 1'b0;
            r_fill_prev <= RESET_SEED;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pending   <= n_pending;
            r_rp        <= n_rp;
            r_wv        <= n_wv;
            r_variant   <= n_variant;
            r_inflight  <= issue;
            r_fill_prev <= n_fill_prev;
        end
    end

    // Hold current twist word and the halve flag of the word in flight
    always_ff @(posedge i_clk) begin
        if (r_state == ST_TWRUN) begin
            r_cur <= r_rd_a;
        end
        if (issue) begin
            r_rd_halve <= i_req.halve;
        end
    end

    assign o_rd.valid = r_inflight;
    assign o_rd.halve = r_rd_halve;
    assign o_rd.word  = r_rd_a;

endmodule

// ----- hw/rtl/mtwg_out.sv -----
// Output stage: tempers store words and buffers them for the consumer.
module mtwg_out
    import mtwg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_rd                  i_rd,
    output logic [OUT_CNT_W-1:0] o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_random_word
);

    logic [31:0]          r_buf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic [31:0]          tempered, result;
    logic                 pop;

    // Temper, then drop the low bit when halving
    always_comb begin
        tempered = temper(i_rd.word);
        result   = i_rd.halve ? (tempered >> 1) : tempered;
    end

    assign o_free        = OUT_CNT_W'(OUT_DEPTH) - r_count;
    assign o_out_valid   = (r_count != '0);
    assign pop           = o_out_valid && !i_out_stall;
    assign o_random_word = r_buf[r_rd_ptr];

    // Store result words
    always_ff @(posedge i_clk) begin
        if (i_rd.valid) begin
            r_buf[r_wr_ptr] <= result;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_rd.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OUT_CNT_W'(i_rd.valid) - OUT_CNT_W'(pop);
        end
    end

endmodule

// ----- hw/rtl/mt19937_word_generator.sv -----
// Top level of the MT19937 word generator: request queue, store engine, output stage.
//
//  Channel  Direction  Handshake                    Payload
//  in       to block   i_in_valid / o_in_stall      i_halve
//  out      from block o_out_valid / i_out_stall    o_random_word
//  cfg      to block   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// After reset or a seed write the store is filled one word a cycle
// through a single 32x32 multiplier; requests queue meanwhile.
// Every 624 words the store is regenerated in place, limited by the store's one
// write port. Otherwise one word a cycle while the output buffer has room, read
// through the store's registered read port and then written to the output buffer.
// Reset is synchronous and active low; the output buffer holds four words, so the
// consumer may stall without losing any.
module mt19937_word_generator
    import mtwg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_halve,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [31:0]            o_random_word,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    t_req                 req;
    t_rd                  rd;
    t_cfg_wr              cfg;
    logic                 pop;
    logic [OUT_CNT_W-1:0] free;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid && o_cfg_ready;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    mtwg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_halve    (i_halve),
        .o_req      (req),
        .i_pop      (pop)
    );

    mtwg_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_pop   (pop),
        .i_free  (free),
        .o_rd    (rd)
    );

    mtwg_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd          (rd),
        .o_free        (free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word)
    );

endmodule

// ----- sim/mt19937_word_generator_test.sv -----
`timescale 1ns / 1ps
// MT19937 word generator self-checking testbench: directed table, scripted runs, random phases.
module mt19937_word_generator_test
    import mtwg_pkg::*;
();

    localparam int CLK_PERIOD    = 8;
    localparam int TOTAL_WORDS   = 1100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 12;
    localparam int MAX_PRINTS    = 20;

    // Generator constants, kept apart from the design's own copies
    localparam int          STORE_DEPTH   = 624;
    localparam int          FAR_DISTANCE  = 397;
    localparam logic [31:0] SEED_FACTOR   = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR     = 32'h9908b0df;
    localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_MASK_C = 32'hefc60000;
    localparam logic [31:0] POWERUP_SEED  = 32'd5489;

    // Register indexes past the end of the register list
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic                   halve;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
        logic                   typed;
        logic [31:0]            want;
    } t_row;

    localparam int DIRECTED_ROWS = 20;

    // Directed rows; typed words are the well-known first outputs for seed 5489
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b1, 32'd3499211612},
        '{ROW_WORD, 1'b1, CFG_SEED,    32'd0,          1'b1, 32'd290934651},
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b1, 32'd3890346734},
        '{ROW_WORD, 1'b1, CFG_SEED,    32'd0,          1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_VARIANT, 32'h0000_0001,  1'b0, 32'd0},
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_SPARE_2, 32'hffff_ffff,  1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_SPARE_3, 32'h0000_0000,  1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_SEED,    32'h0000_0000,  1'b0, 32'd0},
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b0, 32'd0},
        '{ROW_WORD, 1'b1, CFG_SEED,    32'd0,          1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_SEED,    32'hffff_ffff,  1'b0, 32'd0},
        '{ROW_WORD, 1'b1, CFG_SEED,    32'd0,          1'b0, 32'd0},
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_VARIANT, 32'hffff_fffe,  1'b0, 32'd0},
        '{ROW_REG,  1'b0, CFG_SEED,    32'd5489,       1'b0, 32'd0},
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b1, 32'd3499211612},
        '{ROW_WORD, 1'b1, CFG_SEED,    32'd0,          1'b1, 32'd290934651},
        '{ROW_REG,  1'b0, CFG_SEED,    32'h8000_0001,  1'b0, 32'd0},
        '{ROW_WORD, 1'b0, CFG_SEED,    32'd0,          1'b0, 32'd0}
    };

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   i_halve      = 1'b0;
    logic                   i_out_stall  = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [31:0]            i_cfg_data   = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [31:0]            o_random_word;
    logic                   o_cfg_ready;

    // Stimulus-owned controls read by the output side
    logic hold_request = 1'b0;
    logic steady_mode  = 1'b0;

    // Generator state as the testbench predicts it
    logic [31:0] model_store [STORE_DEPTH];
    int unsigned model_pending;
    int unsigned model_position;
    logic        model_legacy;

    logic [31:0] expected_words [$];

    int error_count   = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int reg_writes    = 0;
    int reseeds       = 0;
    int long_holds    = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    int stall_left    = 0;

    mt19937_word_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_halve       (i_halve),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Refill the predicted store from a seed
    function automatic void reseed_model(input logic [31:0] seed);
        logic [31:0] prev;
        model_store[0] = seed;
        for (int k = 1; k < STORE_DEPTH; k++) begin
            prev = model_store[k-1];
            model_store[k] = SEED_FACTOR * (prev ^ (prev >> 30)) + 32'(k);
        end
        model_pending  = 0;
        model_position = 0;
    endfunction

    // Regenerate the predicted store in place, in index order
    function automatic void twist_model();
        logic [31:0] far_word;
        logic [31:0] this_word;
        logic [31:0] next_one;
        logic [31:0] joined;
        logic        odd;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            far_word  = model_store[(k + FAR_DISTANCE) % STORE_DEPTH];
            next_one  = model_store[(k + 1) % STORE_DEPTH];
            this_word = model_store[k];
            joined    = {this_word[31], next_one[30:0]};
            odd       = model_legacy ? this_word[0] : next_one[0];
            model_store[k] = far_word ^ (joined >> 1) ^ (odd ? TWIST_XOR : 32'd0);
        end
        model_pending  = STORE_DEPTH;
        model_position = 0;
    endfunction

    // Work out the tempered word for one request
    function automatic logic [31:0] predict_word(input logic halve);
        logic [31:0] y;
        if (model_pending == 0)
            twist_model();
        model_pending--;
        if (model_position >= STORE_DEPTH)
            model_position = 0;
        y = model_store[model_position];
        model_position++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        if (halve)
            y = y >> 1;
        return y;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one word request and hold it until accepted; valid stays high afterwards
    task automatic send_word(input logic halve, input logic typed, input logic [31:0] want);
        logic [31:0] predicted;
        i_in_valid <= 1'b1;
        i_halve    <= halve;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = predict_word(halve);
        expected_words.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // Drop valid and wait until every expected word has arrived
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [31:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_SEED: begin
                reseed_model(data);
                reseeds++;
            end
            CFG_VARIANT: model_legacy = data[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Random gap on the request side: mostly none, a few long
    task automatic pause_sender();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (steady_mode || roll < 65)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_seed();
        int roll;
        roll = $urandom_range(0, 5);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Check accepted words and drive the output stall
    always @(posedge i_clk) begin : out_side
        int roll;
        logic [31:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with none expected", o_random_word, 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (o_random_word !== want)
                    report_mismatch("random_word", o_random_word, want);
            end
            words_checked++;
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_request) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (steady_mode || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                i_out_stall <= 1'b0;
            end else if (roll < 95) begin
                stall_left  <= $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                stall_left  <= $urandom_range(8, 40);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("mt19937_word_generator test failed");
            $finish;
        end
    end

    initial begin
        t_row row;
        int   phase;
        int   phase_len;
        int   roll;
        model_legacy = 1'b0;
        reseed_model(POWERUP_SEED);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_REG)
                write_register(row.index, row.data);
            else
                send_word(row.halve, row.typed, row.want);
        end

        // Legacy twist across a regeneration without reseeding
        write_register(CFG_VARIANT, $urandom | 32'd1);
        for (int n = 0; n < 700; n++) begin
            send_word(1'($urandom_range(0, 1)), 1'b0, 32'd0);
            pause_sender();
        end

        // Reseed and let the refill and first regeneration finish
        write_register(CFG_SEED, pick_seed());
        send_word(1'b0, 1'b0, 32'd0);
        wait_idle();

        // Long output hold while requests keep coming, then drain fully
        hold_request <= 1'b1;
        @(posedge i_clk);
        hold_request <= 1'b0;
        long_holds++;
        for (int n = 0; n < 40; n++)
            send_word(1'($urandom_range(0, 1)), 1'b0, 32'd0);
        wait_idle();

        // Random phases, each behind a register change
        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            roll = $urandom_range(0, 9);
            if (roll <= 4) begin
                write_register(CFG_SEED, pick_seed());
            end else if (roll <= 7) begin
                write_register(CFG_VARIANT, $urandom);
            end else if (roll == 8) begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
                write_register(CFG_VARIANT, $urandom);
            end else begin
                write_register(CFG_VARIANT, $urandom);
                write_register(CFG_SEED, pick_seed());
            end
            steady_mode <= ($urandom_range(0, 3) == 0);
            phase_len = ($urandom_range(0, 5) == 0) ? 650 : $urandom_range(30, 200);
            for (int n = 0; n < phase_len && words_sent < TOTAL_WORDS; n++) begin
                send_word(1'($urandom_range(0, 1)), 1'b0, 32'd0);
                pause_sender();
            end
            phase++;
        end

        // Wait out the tail and catch any stray word
        steady_mode <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d words (%0d checked), %0d register writes, %0d reseeds, %0d phases",
                 words_sent, words_checked, reg_writes, reseeds, phase);
        $display("both twist variants, halved and full words, %0d long output hold(s)",
                 long_holds);
        if (error_count == 0)
            $display("mt19937_word_generator test passed");
        else
            $display("mt19937_word_generator test failed");
        $finish;
    end

endmodule
